[hdl/cet_pkg.sv]
// ----------------------------------------------------------------------------
// Expression tokeniser package
// Shared types, character constants and character-class helpers.
// ----------------------------------------------------------------------------
package cet_pkg;

  // Width of the running position counter; token start offsets are its low bits.
  localparam int unsigned POSITION_BITS = 16;
  localparam logic [POSITION_BITS-1:0] POS_ONE = POSITION_BITS'(1);

  // Result buffer depth: room for two items' worth of tokens.
  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned FIFO_AW    = $clog2(FIFO_DEPTH);
  localparam int unsigned FIFO_CW    = $clog2(FIFO_DEPTH + 1);

  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_CARET  = 8'h5E;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_D      = 8'h64;
  localparam logic [7:0] CH_E      = 8'h65;
  localparam logic [7:0] CH_P      = 8'h70;
  localparam logic [7:0] CH_I      = 8'h69;
  localparam logic [7:0] CH_POINT  = 8'h2E;
  localparam logic [7:0] CH_UNDER  = 8'h5F;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_NUL    = 8'h00;

  localparam logic [31:0] INT_MAX = 32'h7FFF_FFFF;

  typedef enum logic [7:0] {
    MODE_START = 8'b0000_0001,
    MODE_E     = 8'b0000_0010,
    MODE_PI1   = 8'b0000_0100,
    MODE_PI2   = 8'b0000_1000,
    MODE_DICE  = 8'b0001_0000,
    MODE_ID    = 8'b0010_0000,
    MODE_INT   = 8'b0100_0000,
    MODE_DEC   = 8'b1000_0000
  } scan_mode_e;

  typedef enum logic [3:0] {
    TK_INT   = 4'd0,
    TK_DEC   = 4'd1,
    TK_EULER = 4'd2,
    TK_PI    = 4'd3,
    TK_OP    = 4'd4,
    TK_DICE  = 4'd5,
    TK_ID    = 4'd6,
    TK_END   = 4'd7,
    TK_ERR   = 4'd8
  } tok_kind_e;

  typedef struct packed {
    tok_kind_e   kind;
    logic [7:0]  chr;
    logic [15:0] start;
    logic [15:0] len;
    logic [31:0] mant;
    logic [7:0]  frac;
    logic        last;
  } token_t;

  typedef struct packed {
    scan_mode_e               mode;
    logic                     stopped;
    logic [POSITION_BITS-1:0] pos;
    logic [POSITION_BITS-1:0] tstart;
    logic [15:0]              len;
    logic [31:0]              acc;
    logic [7:0]               frac;
  } scan_state_t;

  // Tokens produced by one character, packed from the front.
  typedef struct packed {
    logic [1:0] n;
    token_t     tok0;
    token_t     tok1;
  } step_out_t;

  function automatic logic is_digit(input logic [7:0] c);
    return c inside {[8'h30:8'h39]};
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    return c inside {[8'h41:8'h5A], [8'h61:8'h7A]};
  endfunction

  function automatic logic is_alnum(input logic [7:0] c);
    return is_digit(c) || is_alpha(c);
  endfunction

  function automatic logic is_idc(input logic [7:0] c);
    return is_alnum(c) || (c == CH_UNDER);
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    return (c == CH_SPACE) || (c inside {[8'h09:8'h0D]});
  endfunction

  function automatic logic is_op(input logic [7:0] c);
    return c inside {CH_PLUS, CH_MINUS, CH_SLASH, CH_STAR, CH_CARET,
                     CH_COMMA, CH_LPAREN, CH_RPAREN};
  endfunction

  // acc * 10 + digit, saturating at all ones; c is known to be a digit.
  function automatic logic [31:0] add_digit(input logic [31:0] acc, input logic [7:0] c);
    logic [35:0] v;
    v = ({4'b0, acc} << 3) + ({4'b0, acc} << 1) + 36'(c[3:0]);
    return (v[35:32] != 4'd0) ? 32'hFFFF_FFFF : v[31:0];
  endfunction

  function automatic logic [15:0] sat_inc16(input logic [15:0] v);
    return (v == 16'hFFFF) ? v : v + 16'd1;
  endfunction

  function automatic logic [7:0] sat_inc8(input logic [7:0] v);
    return (v == 8'hFF) ? v : v + 8'd1;
  endfunction

endpackage

[hdl/cet_if.sv]
// ----------------------------------------------------------------------------
// Expression tokeniser channels
// Character input channel and token output channel, valid/ready handshake.
// ----------------------------------------------------------------------------
interface cet_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] character;

  modport source (output valid, output character, input ready);
  modport sink   (input valid, input character, output ready);
endinterface

interface cet_tok_if;
  logic        valid;
  logic        ready;
  logic [3:0]  token_kind;
  logic [7:0]  token_char;
  logic [15:0] start_position;
  logic [15:0] token_length;
  logic [31:0] number_mantissa;
  logic [7:0]  fraction_digits;
  logic        last;

  modport source (output valid, output token_kind, output token_char,
                  output start_position, output token_length,
                  output number_mantissa, output fraction_digits,
                  output last, input ready);
  modport sink   (input valid, input token_kind, input token_char,
                  input start_position, input token_length,
                  input number_mantissa, input fraction_digits,
                  input last, output ready);
endinterface

[hdl/calculator_expression_tokenizer_core.sv]
// ----------------------------------------------------------------------------
// Calculator expression tokeniser
// Lexer for arithmetic expressions: one character per item in, tokens out.
// ----------------------------------------------------------------------------
//
//   Channel   Direction  Item carries
//   char_i    in         one byte of the expression (0 ends the input)
//   tok_o     out        one finished token with position, length and value
//
// Each accepted item is held in the input register and stepped through the
// lexer from there, its tokens landing in a four-entry result buffer that
// drives the output; a new item can be taken in every cycle while the
// buffer has room.
// An item is only stepped when the buffer has room for two tokens, so a
// stalled output holds the input register and then drops char_i.ready.
// Reset clears the scan state, the position counter and the buffer.
// After an end or error token, later items are taken and give no tokens.
//
// ----------------------------------------------------------------------------
module calculator_expression_tokenizer_core import cet_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  cet_char_if.sink      char_i,
  cet_tok_if.source     tok_o
);

  // Input register: the character waiting to be stepped.
  logic [7:0]          chr_q;
  logic                chr_valid_q;

  // Lexer state, updated once per stepped item.
  scan_state_t         state_q;
  scan_state_t         state_nxt;
  step_out_t           step_out;
  step_out_t           push;

  logic [FIFO_CW-1:0]  buf_cnt;
  token_t              head;
  logic                room;
  logic                fire;
  logic                pop;

  // Room for two tokens means any item can be stepped without loss.
  assign room = (buf_cnt <= FIFO_CW'(FIFO_DEPTH - 2));
  assign fire = chr_valid_q && room;

  // The input register frees up in the same cycle it is stepped, so the
  // stream keeps moving at one item per cycle while the buffer has room.
  assign char_i.ready = !chr_valid_q || room;

  always_ff @(posedge clk_i) begin
    if (char_i.valid && char_i.ready) begin
      chr_q <= char_i.character;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chr_valid_q <= 1'b0;
    end else if (char_i.valid && char_i.ready) begin
      chr_valid_q <= 1'b1;
    end else if (fire) begin
      chr_valid_q <= 1'b0;
    end
  end

  cet_step u_step (
    .chr_i (chr_q),
    .cur_i (state_q),
    .nxt_o (state_nxt),
    .out_o (step_out)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q.mode    <= MODE_START;
      state_q.stopped <= 1'b0;
      state_q.pos     <= '0;
      state_q.tstart  <= '0;
      state_q.len     <= '0;
      state_q.acc     <= '0;
      state_q.frac    <= '0;
    end else if (fire) begin
      state_q <= state_nxt;
    end
  end

  // Tokens are only written into the buffer for an item actually stepped.
  always_comb begin
    push   = step_out;
    push.n = fire ? step_out.n : 2'd0;
  end

  assign pop = tok_o.valid && tok_o.ready;

  cet_tok_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .pop_i  (pop),
    .cnt_o  (buf_cnt),
    .head_o (head)
  );

  assign tok_o.valid           = (buf_cnt != '0);
  assign tok_o.token_kind      = head.kind;
  assign tok_o.token_char      = head.chr;
  assign tok_o.start_position  = head.start;
  assign tok_o.token_length    = head.len;
  assign tok_o.number_mantissa = head.mant;
  assign tok_o.fraction_digits = head.frac;
  assign tok_o.last            = head.last;

  // The buffer never holds more tokens than it has entries.
  a_buf_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    buf_cnt <= FIFO_CW'(FIFO_DEPTH))
    else $error("result buffer overfilled");

  // Once an end or error token has been produced the lexer stays stopped.
  a_stop_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.stopped |=> state_q.stopped)
    else $error("stopped state left without reset");

  // A stopped lexer produces no tokens.
  a_stop_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && state_q.stopped) |-> (push.n == 2'd0))
    else $error("token produced after end of input");

  // End and error tokens are always the final token of their item.
  a_end_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (tok_o.valid && (head.kind == TK_END || head.kind == TK_ERR)) |-> head.last)
    else $error("end or error token not marked last");

endmodule

[hdl/cet_step.sv]
// ----------------------------------------------------------------------------
// Expression tokeniser step
// One lexer transition: next scan state and up to two finished tokens.
// ----------------------------------------------------------------------------
module cet_step import cet_pkg::*; (
  input  logic [7:0]  chr_i,
  input  scan_state_t cur_i,
  output scan_state_t nxt_o,
  output step_out_t   out_o
);

  scan_state_t s;
  logic        keep;
  logic        emit_a;
  logic        emit_b;
  token_t      tok_a;
  token_t      tok_b;

  always_comb begin
    s      = cur_i;
    keep   = 1'b0;
    emit_a = 1'b0;
    emit_b = 1'b0;
    tok_a  = '0;
    tok_b  = '0;
    tok_a.start = 16'(cur_i.tstart);
    tok_a.len   = cur_i.len;
    tok_b.start = 16'(cur_i.pos);

    if (!cur_i.stopped) begin
      // Continue or close the pending token.
      case (cur_i.mode)
        MODE_DICE: begin
          if (is_alpha(chr_i)) begin
            keep   = 1'b1;
            s.mode = MODE_ID;
          end else begin
            emit_a     = 1'b1;
            tok_a.kind = TK_DICE;
            tok_a.chr  = CH_D;
          end
        end
        MODE_E: begin
          if (is_alnum(chr_i)) begin
            keep   = 1'b1;
            s.mode = MODE_ID;
          end else begin
            emit_a     = 1'b1;
            tok_a.kind = TK_EULER;
          end
        end
        MODE_PI1: begin
          if (chr_i == CH_I) begin
            keep   = 1'b1;
            s.mode = MODE_PI2;
          end else if (is_idc(chr_i)) begin
            keep   = 1'b1;
            s.mode = MODE_ID;
          end else begin
            emit_a     = 1'b1;
            tok_a.kind = TK_ID;
          end
        end
        MODE_PI2: begin
          if (is_idc(chr_i)) begin
            keep   = 1'b1;
            s.mode = MODE_ID;
          end else begin
            emit_a     = 1'b1;
            tok_a.kind = TK_PI;
          end
        end
        MODE_ID: begin
          if (is_alnum(chr_i)) begin
            keep = 1'b1;
          end else begin
            emit_a     = 1'b1;
            tok_a.kind = TK_ID;
          end
        end
        MODE_INT: begin
          if (chr_i == CH_POINT) begin
            keep   = 1'b1;
            s.mode = MODE_DEC;
          end else if (is_digit(chr_i)) begin
            keep  = 1'b1;
            s.acc = add_digit(cur_i.acc, chr_i);
          end else begin
            emit_a     = 1'b1;
            tok_a.kind = TK_INT;
            tok_a.mant = cur_i.acc[31] ? INT_MAX : cur_i.acc;
          end
        end
        MODE_DEC: begin
          if (is_digit(chr_i)) begin
            keep   = 1'b1;
            s.acc  = add_digit(cur_i.acc, chr_i);
            s.frac = sat_inc8(cur_i.frac);
          end else begin
            emit_a     = 1'b1;
            tok_a.kind = TK_DEC;
            tok_a.mant = cur_i.acc;
            tok_a.frac = cur_i.frac;
          end
        end
        default: begin
        end
      endcase

      if (keep) begin
        s.pos = cur_i.pos + POS_ONE;
        s.len = sat_inc16(cur_i.len);
      end else begin
        // The character is looked at again from the start state.
        s.mode   = MODE_START;
        s.tstart = cur_i.pos;
        s.len    = 16'd0;
        s.acc    = '0;
        s.frac   = '0;
        if (is_op(chr_i)) begin
          s.pos      = cur_i.pos + POS_ONE;
          emit_b     = 1'b1;
          tok_b.kind = TK_OP;
          tok_b.chr  = chr_i;
          tok_b.len  = 16'd1;
        end else if (chr_i == CH_D) begin
          s.pos  = cur_i.pos + POS_ONE;
          s.len  = 16'd1;
          s.mode = MODE_DICE;
        end else if (chr_i == CH_E) begin
          s.pos  = cur_i.pos + POS_ONE;
          s.len  = 16'd1;
          s.mode = MODE_E;
        end else if (chr_i == CH_P) begin
          s.pos  = cur_i.pos + POS_ONE;
          s.len  = 16'd1;
          s.mode = MODE_PI1;
        end else if (is_digit(chr_i)) begin
          s.pos  = cur_i.pos + POS_ONE;
          s.len  = 16'd1;
          s.acc  = 32'(chr_i[3:0]);
          s.mode = MODE_INT;
        end else if (is_alpha(chr_i)) begin
          s.pos  = cur_i.pos + POS_ONE;
          s.len  = 16'd1;
          s.mode = MODE_ID;
        end else if (is_space(chr_i)) begin
          s.pos = cur_i.pos + POS_ONE;
        end else begin
          emit_b     = 1'b1;
          tok_b.kind = (chr_i == CH_NUL) ? TK_END : TK_ERR;
          s.stopped  = 1'b1;
        end
      end
    end
  end

  always_comb begin
    out_o = '0;
    if (emit_a && emit_b) begin
      out_o.n         = 2'd2;
      out_o.tok0      = tok_a;
      out_o.tok1      = tok_b;
      out_o.tok1.last = 1'b1;
    end else if (emit_a) begin
      out_o.n         = 2'd1;
      out_o.tok0      = tok_a;
      out_o.tok0.last = 1'b1;
    end else if (emit_b) begin
      out_o.n         = 2'd1;
      out_o.tok0      = tok_b;
      out_o.tok0.last = 1'b1;
    end
  end

  assign nxt_o = s;

endmodule

[hdl/cet_tok_fifo.sv]
// ----------------------------------------------------------------------------
// Expression tokeniser result buffer
// Small token queue that takes up to two tokens and gives one per cycle when popped.
// ----------------------------------------------------------------------------
module cet_tok_fifo import cet_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  step_out_t          push_i,
  input  logic               pop_i,
  output logic [FIFO_CW-1:0] cnt_o,
  output token_t             head_o
);

  token_t               mem_q [FIFO_DEPTH];
  logic [FIFO_AW-1:0]   wr_q, wr_d;
  logic [FIFO_AW-1:0]   rd_q, rd_d;
  logic [FIFO_CW-1:0]   cnt_q, cnt_d;
  logic [FIFO_AW-1:0]   wr_next;

  assign wr_next = wr_q + FIFO_AW'(1);

  always_ff @(posedge clk_i) begin
    if (push_i.n != 2'd0) begin
      mem_q[wr_q] <= push_i.tok0;
    end
    if (push_i.n == 2'd2) begin
      mem_q[wr_next] <= push_i.tok1;
    end
  end

  always_comb begin
    wr_d  = wr_q + FIFO_AW'(push_i.n);
    rd_d  = rd_q + FIFO_AW'(pop_i);
    cnt_d = cnt_q + FIFO_CW'(push_i.n) - FIFO_CW'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  assign cnt_o  = cnt_q;
  assign head_o = mem_q[rd_q];

endmodule
